### rtl/core/tiacf_pkg.sv
// ============================================================================
// tiacf_pkg
// Shared types and byte codes for the telnet command and control-byte filter.
// ============================================================================
package tiacf_pkg;

    localparam int unsigned BYTE_W = 8;
    // room for the two results a single byte can cause
    localparam int unsigned OB_DEPTH = 2;

    localparam logic [BYTE_W-1:0] C_IAC       = 8'd255;
    localparam logic [BYTE_W-1:0] C_ESC       = 8'd27;
    localparam logic [BYTE_W-1:0] C_BRACKET   = 8'd91;
    localparam logic [BYTE_W-1:0] C_LF        = 8'd10;
    localparam logic [BYTE_W-1:0] C_CR        = 8'd13;
    localparam logic [BYTE_W-1:0] C_CTRL_LIM  = 8'd32;
    localparam logic [BYTE_W-1:0] C_CMD_LO    = 8'd240;
    localparam logic [BYTE_W-1:0] C_CMD_HI    = 8'd250;
    localparam logic [BYTE_W-1:0] C_VERB_LO   = 8'd251;
    localparam logic [BYTE_W-1:0] C_VERB_HI   = 8'd254;

    // telnet sequence phase
    typedef enum logic [2:0] {
        PH_DATA   = 3'b001,
        PH_IAC    = 3'b010,
        PH_OPTION = 3'b100
    } t_phase;

    // results decoded for one request
    typedef struct packed {
        logic [1:0]        cnt;
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
    } t_filt_res;

    // result buffer status towards the filter
    typedef struct packed {
        logic [1:0] free;
    } t_ob_stat;

endpackage

### rtl/core/tiacf_if.sv
// ============================================================================
// tiacf_if
// Valid/ready channels for raw input bytes and filtered result bytes.
// ============================================================================
interface tiacf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface tiacf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

### rtl/core/tiacf_filter.sv
// ============================================================================
// tiacf_filter
// Telnet phase and ESC-hold state with the per-byte decode.
// ============================================================================
module tiacf_filter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [7:0]              i_byte,
    input  logic                    i_last,
    input  tiacf_pkg::t_ob_stat     i_stat,
    output logic                    o_fire,
    output tiacf_pkg::t_filt_res    o_res
);
    import tiacf_pkg::*;

    t_phase r_phase, n_phase;
    logic   r_esc, n_esc;

    always_comb begin
        logic pre_esc;
        logic is_ctrl;
        o_res   = '0;
        n_phase = PH_DATA;
        n_esc   = 1'b0;
        pre_esc = 1'b0;
        is_ctrl = (i_byte < C_CTRL_LIM) && (i_byte != C_LF) && (i_byte != C_CR);

        case (r_phase)
            PH_OPTION: begin
                // option byte: drop whatever it is
                n_phase = PH_DATA;
            end
            PH_IAC: begin
                if (i_byte == C_IAC) begin
                    o_res.cnt   = 2'd1;
                    o_res.byte0 = C_IAC;
                end else if (i_byte inside {[C_CMD_LO:C_CMD_HI]}) begin
                    n_phase = PH_DATA;
                end else if (i_byte inside {[C_VERB_LO:C_VERB_HI]}) begin
                    n_phase = PH_OPTION;
                end else if (is_ctrl) begin
                    n_esc = (i_byte == C_ESC) && !i_last;
                end else begin
                    o_res.cnt   = 2'd1;
                    o_res.byte0 = i_byte;
                end
            end
            default: begin
                // held ESC survives only when '[' follows
                pre_esc = r_esc && (i_byte == C_BRACKET);
                if (i_byte == C_IAC) begin
                    n_phase = PH_IAC;
                end else if (is_ctrl) begin
                    n_esc = (i_byte == C_ESC) && !i_last;
                end else if (pre_esc) begin
                    o_res.cnt   = 2'd2;
                    o_res.byte0 = C_ESC;
                    o_res.byte1 = i_byte;
                end else begin
                    o_res.cnt   = 2'd1;
                    o_res.byte0 = i_byte;
                end
            end
        endcase
    end

    assign o_fire = i_valid && (o_res.cnt <= i_stat.free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_esc   <= 1'b0;
        end else if (o_fire) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
        end
    end

endmodule

### rtl/core/tiacf_outbuf.sv
// ============================================================================
// tiacf_outbuf
// Two-entry result buffer: takes up to two results, pops one a cycle on ready.
// ============================================================================
module tiacf_outbuf (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  tiacf_pkg::t_filt_res    i_res,
    output tiacf_pkg::t_ob_stat     o_stat,
    tiacf_out_if.source             o_out
);
    import tiacf_pkg::*;

    logic [BYTE_W-1:0] r_byte [OB_DEPTH];
    logic              r_last [OB_DEPTH];
    logic [1:0]        r_cnt;

    logic [BYTE_W-1:0] n_byte [OB_DEPTH];
    logic              n_last [OB_DEPTH];
    logic [1:0]        n_cnt;
    logic              pop;
    logic [1:0]        keep_cnt;
    logic [1:0]        push_cnt;

    assign pop         = (r_cnt != 2'd0) && o_out.ready;
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_byte[0];
    assign o_out.run_last = r_last[0];

    assign keep_cnt    = r_cnt - {1'b0, pop};
    assign o_stat.free = 2'd2 - keep_cnt;
    assign push_cnt    = i_push ? i_res.cnt : 2'd0;
    assign n_cnt       = keep_cnt + push_cnt;

    always_comb begin
        logic [1:0] j;
        for (int i = 0; i < OB_DEPTH; i++) begin
            j = 2'(i) - keep_cnt;
            if (2'(i) < keep_cnt) begin
                // advance surviving entries
                n_byte[i] = pop ? r_byte[1] : r_byte[i];
                n_last[i] = pop ? r_last[1] : r_last[i];
            end else if (j == 2'd0) begin
                n_byte[i] = i_res.byte0;
                n_last[i] = (i_res.cnt == 2'd1);
            end else begin
                n_byte[i] = i_res.byte1;
                n_last[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < OB_DEPTH; i++) begin
            r_byte[i] <= n_byte[i];
            r_last[i] <= n_last[i];
        end
    end

endmodule

### rtl/core/telnet_iac_and_control_filter_top.sv
// ============================================================================
// telnet_iac_and_control_filter_top
// Strips telnet commands and stray control bytes from a server byte stream.
// ============================================================================
// Usage:
//   i_in  : raw server bytes, one request per byte, with chunk_end set on the
//           last byte of a received chunk.
//   o_out : filtered bytes; run_last marks the final result a byte caused.
//           A byte causes zero, one or two results (ESC followed by '['
//           gives two).
//   Path: a byte is held in the input register, decoded once the result
//   buffer has room for its results, and registered into that buffer,
//   from which o_out presents its first result.
//   Throughput: one byte per cycle while the receiver takes one result per
//   cycle; the single output port hands out a two-result byte one at a time.
//   The two-entry result buffer sets how far decode can run ahead of o_out.
//   Reset: synchronous, active low; the phase returns to plain data, no ESC
//   is held and the result buffer empties.
//   Stall: when o_out.ready is low the buffer fills, decode holds the byte in
//   the input register, and i_in.ready drops once that register is occupied.
// ============================================================================
module telnet_iac_and_control_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tiacf_in_if.sink    i_in,
    tiacf_out_if.source o_out
);
    import tiacf_pkg::*;

    // input register
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic       fire;
    logic       accept;
    t_filt_res  res;
    t_ob_stat   stat;

    // take a new request whenever the held one is empty or leaves now
    assign i_in.ready = !r_in_valid || fire;
    assign accept     = i_in.valid && i_in.ready;
    assign n_in_valid = accept || (r_in_valid && !fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.chunk_end;
        end
    end

    // decode: fires only when the buffer has room for every result
    tiacf_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_stat  (stat),
        .o_fire  (fire),
        .o_res   (res)
    );

    // result buffer towards the parser
    tiacf_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_res   (res),
        .o_stat  (stat),
        .o_out   (o_out)
    );

    // a decoded byte never overflows the result buffer
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> (res.cnt <= stat.free))
        else $error("result buffer overflow");

    // a held request is kept until decode takes it
    a_hold_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> r_in_valid)
        else $error("held request lost");

    // decoded results show up on the output in the next cycle
    a_result_shown : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (res.cnt != 2'd0)) |=> o_out.valid)
        else $error("decoded result not presented");

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the telnet command and control-byte filter: a short
// table of directed bytes, then a long stream of random telnet sequences, ESC
// sequences and noise.
// Each accepted request runs through a behavioural filter model. The results
// it predicts (or, for typed rows, the results the table states) wait in order,
// and every result the block hands out is compared field by field against the oldest one.
// ============================================================================
module tb;
    import tiacf_pkg::*;

    localparam int unsigned RAND_ITEMS  = 1450;
    localparam int unsigned MAX_GAP     = 8;
    localparam int unsigned QUIET_SPAN  = 120;   // length of a burst with no idling
    localparam int unsigned HOLD_AT     = 300;   // result count that starts the long hold
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_TAIL  = 16;

    localparam logic TYPED     = 1'b1;   // row carries its own expected results
    localparam logic PREDICTED = 1'b0;   // row is checked against the model

    // one row of the directed table
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              chunk_end;
        logic              typed;
        logic [1:0]        cnt;
        logic [BYTE_W-1:0] res0;
        logic [BYTE_W-1:0] res1;
    } t_row;

    // one expected filtered byte
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_filtered;

    localparam int unsigned N_ROWS = 30;
    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{8'd65,  1'b0, TYPED,     2'd1, 8'd65,  8'd0},   // plain printable
        '{8'd0,   1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // NUL removed
        '{8'd255, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // IAC opens
        '{8'd255, 1'b0, TYPED,     2'd1, 8'd255, 8'd0},   // IAC IAC gives 255
        '{8'd255, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},
        '{8'd240, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // lowest command
        '{8'd255, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},
        '{8'd250, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // highest command
        '{8'd255, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},
        '{8'd251, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // lowest verb
        '{8'd255, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // option 255 dropped
        '{8'd255, 1'b1, TYPED,     2'd0, 8'd0,   8'd0},   // IAC open at chunk end
        '{8'd254, 1'b1, TYPED,     2'd0, 8'd0,   8'd0},   // highest verb, next chunk
        '{8'd0,   1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // option 0 dropped
        '{8'd27,  1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // ESC held
        '{8'd91,  1'b0, TYPED,     2'd2, 8'd27,  8'd91},  // ESC '[' kept
        '{8'd27,  1'b0, TYPED,     2'd0, 8'd0,   8'd0},
        '{8'd27,  1'b0, TYPED,     2'd0, 8'd0,   8'd0},   // ESC replaces held ESC
        '{8'd65,  1'b0, TYPED,     2'd1, 8'd65,  8'd0},   // held ESC dropped
        '{8'd27,  1'b1, TYPED,     2'd0, 8'd0,   8'd0},   // ESC at chunk end
        '{8'd91,  1'b0, TYPED,     2'd1, 8'd91,  8'd0},   // nothing held over
        '{8'd255, 1'b0, TYPED,     2'd0, 8'd0,   8'd0},
        '{8'd239, 1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},   // IAC then data byte
        '{8'd255, 1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},
        '{8'd27,  1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},   // IAC then ESC
        '{8'd91,  1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},
        '{8'd13,  1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},   // CR kept
        '{8'd10,  1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},   // LF kept
        '{8'd31,  1'b0, PREDICTED, 2'd0, 8'd0,   8'd0},   // top control byte
        '{8'd254, 1'b1, PREDICTED, 2'd0, 8'd0,   8'd0}    // high data byte
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tiacf_in_if  in_ch ();
    tiacf_out_if out_ch ();

    telnet_iac_and_control_filter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Filter model: its own phase and ESC hold, mirrored from the block.
    // ------------------------------------------------------------------------
    t_phase            tel_phase = PH_DATA;
    logic              esc_held  = 1'b0;
    logic [BYTE_W-1:0] emitted [$];       // bytes caused by the latest request
    t_filtered         filtered_due [$];  // results still to come from the block

    int unsigned n_sent    = 0;
    int unsigned n_results = 0;
    int unsigned errors    = 0;

    // data-phase handling of a byte with no ESC held
    function void take_plain(input logic [BYTE_W-1:0] b, input logic ce);
        if (b == C_IAC) begin
            tel_phase = PH_IAC;
        end else if (b < C_CTRL_LIM && b != C_LF && b != C_CR) begin
            // drop the control byte; hold an ESC unless the chunk ends here
            if (b == C_ESC && !ce) begin
                esc_held = 1'b1;
            end
        end else begin
            emitted.push_back(b);
        end
    endfunction

    function void filter_byte(input logic [BYTE_W-1:0] b, input logic ce);
        emitted.delete();
        case (tel_phase)
            PH_IAC: begin
                tel_phase = PH_DATA;
                if (b == C_IAC) begin
                    emitted.push_back(C_IAC);
                end else if (b >= C_CMD_LO && b <= C_CMD_HI) begin
                    // drop the command
                end else if (b >= C_VERB_LO && b <= C_VERB_HI) begin
                    tel_phase = PH_OPTION;
                end else begin
                    take_plain(b, ce);
                end
            end
            PH_OPTION: begin
                // drop the option byte, whatever it is
                tel_phase = PH_DATA;
            end
            default: begin
                tel_phase = PH_DATA;
                if (esc_held) begin
                    esc_held = 1'b0;
                    if (b == C_BRACKET) begin
                        emitted.push_back(C_ESC);
                    end
                end
                take_plain(b, ce);
            end
        endcase
    endfunction

    function void queue_emitted();
        foreach (emitted[i]) begin
            filtered_due.push_back('{data: emitted[i], last: (i == emitted.size() - 1)});
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request side: idle for a random gap, offer the byte, hold it until the
    // block takes it. Every third span of requests runs with no idling.
    // ------------------------------------------------------------------------
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic ce);
        int unsigned gap;
        gap = ((n_sent / QUIET_SPAN) % 3 == 0) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.chunk_end <= ce;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    initial begin
        logic [BYTE_W-1:0] seq [$];
        int unsigned       kind;

        // hold every input at a known value from time zero
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= '0;
        in_ch.chunk_end <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        for (int r = 0; r < N_ROWS; r++) begin
            offer_byte(DIR_ROWS[r].data, DIR_ROWS[r].chunk_end);
            filter_byte(DIR_ROWS[r].data, DIR_ROWS[r].chunk_end);
            if (DIR_ROWS[r].typed) begin
                // the table states the results; the model only tracks state
                if (DIR_ROWS[r].cnt == 2'd1) begin
                    filtered_due.push_back('{data: DIR_ROWS[r].res0, last: 1'b1});
                end else if (DIR_ROWS[r].cnt == 2'd2) begin
                    filtered_due.push_back('{data: DIR_ROWS[r].res0, last: 1'b0});
                    filtered_due.push_back('{data: DIR_ROWS[r].res1, last: 1'b1});
                end
            end else begin
                queue_emitted();
            end
        end

        // random stream: mostly well-formed sequences with random content,
        // broken up by stray chunk ends, lone ESCs and plain noise
        while (n_sent < N_ROWS + RAND_ITEMS) begin
            seq.delete();
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                seq.push_back(C_IAC);
                seq.push_back(8'($urandom_range(C_VERB_LO, C_VERB_HI)));
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 20) begin
                seq.push_back(C_IAC);
                seq.push_back(8'($urandom_range(C_CMD_LO, C_CMD_HI)));
            end else if (kind < 26) begin
                seq.push_back(C_IAC);
                seq.push_back(C_IAC);
            end else if (kind < 31) begin
                seq.push_back(C_IAC);
                seq.push_back(8'($urandom_range(0, C_CMD_LO - 1)));
            end else if (kind < 43) begin
                seq.push_back(C_ESC);
                seq.push_back(C_BRACKET);
                seq.push_back(8'($urandom_range(32, 126)));
            end else if (kind < 49) begin
                seq.push_back(C_ESC);
                seq.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 58) begin
                seq.push_back(8'($urandom_range(0, C_CTRL_LIM - 1)));
            end else if (kind < 63) begin
                seq.push_back(($urandom_range(0, 1) != 0) ? C_CR : C_LF);
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
            foreach (seq[i]) begin
                logic ce;
                ce = ($urandom_range(0, 7) == 0);
                offer_byte(seq[i], ce);
                filter_byte(seq[i], ce);
                queue_emitted();
            end
        end
        in_ch.valid <= 1'b0;

        // drain, then give the block time to show any stray result
        while (filtered_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (filtered_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, filtered_due.size());
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: stall for a random gap before each result (none in every third
    // span of results), once hold off for a long stretch so the buffer fills and
    // the request side backs up, then take the result and check it.
    // ------------------------------------------------------------------------
    initial begin
        t_filtered   want;
        int unsigned hold;
        bit          pressure_done;

        pressure_done = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);

        forever begin
            hold = ((n_results / QUIET_SPAN) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (!pressure_done && n_results >= HOLD_AT) begin
                pressure_done = 1'b1;
                hold += HOLD_CYCLES;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            n_results++;

            if (filtered_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual byte %02h last %0b",
                         $time, out_ch.out_byte, out_ch.run_last);
            end else begin
                want = filtered_due.pop_front();
                if (out_ch.out_byte !== want.data) begin
                    errors++;
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, want.data, out_ch.out_byte);
                end
                if (out_ch.run_last !== want.last) begin
                    errors++;
                    $display("%0t: run_last mismatch, expected %0b, actual %0b",
                             $time, want.last, out_ch.run_last);
                end
            end
        end
    end

    // abandon a run that hangs
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### telnet_iac_and_control_filter_top.f
rtl/core/tiacf_pkg.sv
rtl/core/tiacf_if.sv
rtl/core/tiacf_filter.sv
rtl/core/tiacf_outbuf.sv
rtl/core/telnet_iac_and_control_filter_top.sv
test/tb.sv
